/* sv/rss_pkg.sv */
// Shared types and constants for the ray-sphere nearest-hit shader.
// Used by the front end, back end and top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rss_pkg;

  // Operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_CAMERA_X      = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y      = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z      = 3'd2;
  localparam logic [2:0] CFG_FADE_DISTANCE = 3'd3;
  localparam logic [2:0] CFG_SPHERE_COUNT  = 3'd4;

  // Register reset values
  localparam logic [19:0] CAMERA_X_RST = 20'sd11520;
  localparam logic [19:0] CAMERA_Y_RST = 20'sd8960;
  localparam logic [19:0] CAMERA_Z_RST = -20'sd25600;
  localparam logic [11:0] FADE_RST     = 12'd280;
  localparam logic [3:0]  COUNT_RST    = 4'd4;

  // Widths of the shared arithmetic units
  localparam int SQ_W  = 46;  // root unit radicand
  localparam int DV_NW = 43;  // divider dividend
  localparam int DV_DW = 20;  // divider divisor

  typedef struct packed {
    logic               op;
    logic [2:0]         slot;
    logic signed [19:0] center_x;
    logic signed [19:0] center_y;
    logic signed [19:0] center_z;
    logic [15:0]        radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [6:0]         pixel_x;
    logic [6:0]         pixel_y;
  } cmd_t;

  typedef struct packed {
    logic signed [19:0] camera_x;
    logic signed [19:0] camera_y;
    logic signed [19:0] camera_z;
    logic [11:0]        fade_distance;
    logic [3:0]         sphere_count;
  } cfg_t;

endpackage
`default_nettype wire

/* sv/rss_front.sv */
// Front end: accepts input items and queues them, two deep, for the back end.
// Depends on rss_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none
module rss_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rss_pkg::cmd_t in_cmd,
  output logic              q_valid,
  input  wire logic         q_pop,
  output rss_pkg::cmd_t     q_cmd
);

  rss_pkg::cmd_t entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = entry[rp];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (push) entry[wp] <= in_cmd;
  end

endmodule
`default_nettype wire

/* sv/rss_sqrt.sv */
// Bit-serial integer square root, two radicand bits a cycle.
// Self-contained; used by rss_back.
`timescale 1ns / 1ps
`default_nettype none
module rss_sqrt #(
  parameter int W = 46
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [W-1:0]   radicand,
  output logic                busy,
  output logic                done,
  output logic [W/2-1:0]      root
);

  localparam int HW = W / 2;
  localparam int RW = HW + 3;
  localparam int CW = $clog2(HW + 1);

  logic [W-1:0]  rad;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic [HW-1:0] res;
  logic [CW-1:0] cnt;
  logic          ge;

  assign rem_sh = {rem[RW-3:0], rad[W-1:W-2]};
  assign trial  = RW'({res, 2'b01});
  assign ge     = (rem_sh >= trial);
  assign root   = res;

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(HW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Take one root bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      rem <= ge ? (rem_sh - trial) : rem_sh;
      res <= {res[HW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* sv/rss_div.sv */
// Bit-serial unsigned restoring divider, one quotient bit a cycle.
// Self-contained; used by rss_back.
`timescale 1ns / 1ps
`default_nettype none
module rss_div #(
  parameter int NW = 43,
  parameter int DW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic [CW-1:0] cnt;
  logic          ge;

  assign rem_sh   = {rem, quo[NW-1]};
  assign diff     = rem_sh - {1'b0, dv};
  assign ge       = (rem_sh >= {1'b0, dv});
  assign quotient = quo;

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* sv/rss_back.sv */
// Back end: sphere table, cast sequencer with one shared multiplier, root unit
// and divider, and the result register. Depends on rss_pkg, rss_sqrt, rss_div.
`timescale 1ns / 1ps
`default_nettype none
module rss_back #(
  parameter int MAX_SPHERES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rss_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire rss_pkg::cmd_t q_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               hit,
  output logic [2:0]         nearest_slot,
  output logic [19:0]        hit_distance,
  output logic [7:0]         shade_red,
  output logic [7:0]         shade_green,
  output logic [7:0]         shade_blue
);

  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int KW = $clog2(MAX_SPHERES + 1);

  localparam int SQ_W_L  = rss_pkg::SQ_W;
  localparam int DV_NW_L = rss_pkg::DV_NW;
  localparam int DV_DW_L = rss_pkg::DV_DW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DOT   = 5'd1;
  localparam logic [4:0] S_LENGO = 5'd2;
  localparam logic [4:0] S_LEN   = 5'd3;
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_DIVGO = 5'd6;
  localparam logic [4:0] S_DIV   = 5'd7;
  localparam logic [4:0] S_TT    = 5'd8;
  localparam logic [4:0] S_D2    = 5'd9;
  localparam logic [4:0] S_CMP   = 5'd10;
  localparam logic [4:0] S_THC   = 5'd11;
  localparam logic [4:0] S_PICK  = 5'd12;
  localparam logic [4:0] S_FIN   = 5'd13;
  localparam logic [4:0] S_SH    = 5'd14;
  localparam logic [4:0] S_SHM   = 5'd15;
  localparam logic [4:0] S_SHW   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  // Dot-product phases: ray length squared, then per-sphere products
  localparam logic [3:0] PH_RAY_END = 4'd3;
  localparam logic [3:0] PH_SPH_BEG = 4'd4;
  localparam logic [3:0] PH_SPH_END = 4'd11;

  localparam logic [1:0] CH_RED  = 2'd0;
  localparam logic [1:0] CH_BLUE = 2'd2;

  // Sphere table
  logic [59:0] centers [MAX_SPHERES];
  logic [39:0] looks   [MAX_SPHERES];
  logic [59:0] cen_rd;
  logic [39:0] look_rd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_idx;
  logic          wr_en;

  logic [4:0]  state;
  logic [3:0]  ph;
  logic [KW-1:0] k;
  logic [KW-1:0] n;
  logic [IW-1:0] best;
  logic [19:0] bestd;
  logic [1:0]  c;

  logic signed [20:0] dx, dy, dz, mx, my, mz;
  logic [15:0]        rad;
  logic [40:0]        a;
  logic [19:0]        len;
  logic signed [43:0] h, mm;
  logic [31:0]        rr;
  logic               hneg;
  logic signed [23:0] tca;
  logic signed [46:0] d2;
  logic [22:0]        thc;
  logic [7:0]         sr, sg, sb;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;

  // Combinational helpers
  logic signed [20:0] dx_new, dy_new, dz_new, mx_new, my_new, mz_new;
  logic signed [19:0] cz;
  logic               behind;
  logic signed [46:0] d2_new;
  logic               d2_gt;
  logic [46:0]        diff;
  logic signed [25:0] t_full;
  logic [25:0]        t_abs;
  logic [19:0]        t_sat;
  logic [19:0]        fq;
  logic [20:0]        fade_left;
  logic [7:0]         col;
  logic [43:0]        habs;
  logic [2:0]         slot_red;

  logic               sq_start, sq_busy, sq_done;
  logic [SQ_W_L-1:0]  sq_in;
  logic [SQ_W_L/2-1:0] sq_root;
  logic               dv_start, dv_busy, dv_done;
  logic [DV_NW_L-1:0] dv_num;
  logic [DV_DW_L-1:0] dv_den;
  logic [DV_NW_L-1:0] dv_q;

  // Active entries, clipped to the table depth
  always_comb begin
    if (int'(cfg.sphere_count) > MAX_SPHERES) n = KW'(MAX_SPHERES);
    else n = KW'(cfg.sphere_count);
  end

  // Fold the slot into the table
  always_comb begin
    slot_red = q_cmd.slot;
    for (int i = 0; i < 8; i++) begin
      if (int'(slot_red) >= MAX_SPHERES) slot_red = slot_red - 3'(MAX_SPHERES);
    end
    wr_idx = IW'(slot_red);
  end

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign wr_en   = q_pop && (q_cmd.op == rss_pkg::OP_WRITE);
  assign rd_addr = (state == S_RD) ? k[IW-1:0] : best;

  // Write and read the table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      centers[wr_idx] <= {q_cmd.center_x, q_cmd.center_y, q_cmd.center_z};
      looks[wr_idx]   <= {q_cmd.radius, q_cmd.red, q_cmd.green, q_cmd.blue};
    end
    cen_rd  <= centers[rd_addr];
    look_rd <= looks[rd_addr];
  end

  // Datapath terms
  always_comb begin
    dx_new = $signed({6'b0, q_cmd.pixel_x, 8'b0}) - $signed({cfg.camera_x[19], cfg.camera_x});
    dy_new = $signed({6'b0, q_cmd.pixel_y, 8'b0}) - $signed({cfg.camera_y[19], cfg.camera_y});
    dz_new = 21'sd0 - $signed({cfg.camera_z[19], cfg.camera_z});
    cz     = $signed(cen_rd[19:0]);
    mx_new = $signed({cen_rd[59], cen_rd[59:40]}) - $signed({cfg.camera_x[19], cfg.camera_x});
    my_new = $signed({cen_rd[39], cen_rd[39:20]}) - $signed({cfg.camera_y[19], cfg.camera_y});
    mz_new = $signed({cz[19], cz}) - $signed({cfg.camera_z[19], cfg.camera_z});
    behind = (cz <= cfg.camera_z);
    d2_new = $signed({{3{mm[43]}}, mm}) - prod[46:0];
    d2_gt  = (d2 > $signed({15'b0, rr}));
    diff   = {15'b0, rr} - d2;
    t_full = $signed({{2{tca[23]}}, tca}) - $signed({3'b0, thc});
    t_abs  = t_full[25] ? 26'(-t_full) : 26'(t_full);
    t_sat  = (t_abs > 26'd1048575) ? 20'hFFFFF : t_abs[19:0];
    fq        = {cfg.fade_distance, 8'b0};
    fade_left = {1'b0, fq} - {1'b0, bestd};
    habs   = h[43] ? 44'(-h) : 44'(h);
    case (c)
      CH_RED:  col = look_rd[23:16];
      CH_BLUE: col = look_rd[7:0];
      default: col = look_rd[15:8];
    endcase
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DOT: begin
        case (ph)
          4'd0:  begin mul_a = 25'(dx); mul_b = 25'(dx); end
          4'd1:  begin mul_a = 25'(dy); mul_b = 25'(dy); end
          4'd2:  begin mul_a = 25'(dz); mul_b = 25'(dz); end
          4'd4:  begin mul_a = 25'(dx); mul_b = 25'(mx); end
          4'd5:  begin mul_a = 25'(dy); mul_b = 25'(my); end
          4'd6:  begin mul_a = 25'(dz); mul_b = 25'(mz); end
          4'd7:  begin mul_a = 25'(mx); mul_b = 25'(mx); end
          4'd8:  begin mul_a = 25'(my); mul_b = 25'(my); end
          4'd9:  begin mul_a = 25'(mz); mul_b = 25'(mz); end
          4'd10: begin mul_a = $signed({9'b0, rad}); mul_b = $signed({9'b0, rad}); end
          default: ;
        endcase
      end
      S_TT: begin mul_a = 25'(tca); mul_b = 25'(tca); end
      S_SH: begin mul_a = $signed({17'b0, col}); mul_b = $signed({4'b0, fade_left}); end
      default: ;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Start the shared units
  always_comb begin
    sq_start = ((state == S_LENGO) && (a != '0)) || ((state == S_CMP) && !d2_gt);
    sq_in    = (state == S_LENGO) ? SQ_W_L'(a) : diff[SQ_W_L-1:0];
    dv_start = (state == S_DIVGO) || (state == S_SHM);
    dv_num   = (state == S_SHM) ? prod[DV_NW_L-1:0] : habs[DV_NW_L-1:0];
    dv_den   = (state == S_SHM) ? fq : len;
  end

  rss_sqrt #(.W(SQ_W_L)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  rss_div #(.NW(DV_NW_L), .DW(DV_DW_L)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_num), .divisor(dv_den),
    .busy(dv_busy), .done(dv_done), .quotient(dv_q)
  );

  // Cast sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop a transferred result unless a new one replaces it this cycle
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && (q_cmd.op == rss_pkg::OP_CAST)) begin
            dx    <= dx_new;
            dy    <= dy_new;
            dz    <= dz_new;
            ph    <= '0;
            k     <= '0;
            best  <= '0;
            bestd <= '0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          ph <= ph + 4'd1;
          case (ph)
            4'd1:        a  <= prod[40:0];
            4'd2, 4'd3:  a  <= a + prod[40:0];
            4'd5:        h  <= prod[43:0];
            4'd6, 4'd7:  h  <= h + prod[43:0];
            4'd8:        mm <= prod[43:0];
            4'd9, 4'd10: mm <= mm + prod[43:0];
            4'd11:       rr <= prod[31:0];
            default: ;
          endcase
          if (ph == PH_RAY_END) state <= S_LENGO;
          if (ph == PH_SPH_END) state <= S_DIVGO;
        end
        S_LENGO: state <= (a == '0) ? S_FIN : S_LEN;
        S_LEN: begin
          if (sq_done) begin
            len   <= sq_root[19:0];
            state <= S_RD;
          end
        end
        S_RD: state <= (k >= n) ? S_FIN : S_CHK;
        S_CHK: begin
          if (behind) begin
            k     <= k + 1'b1;
            state <= S_RD;
          end else begin
            mx    <= mx_new;
            my    <= my_new;
            mz    <= mz_new;
            rad   <= look_rd[39:24];
            ph    <= PH_SPH_BEG;
            state <= S_DOT;
          end
        end
        S_DIVGO: begin
          hneg  <= h[43];
          state <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            tca   <= hneg ? -$signed(dv_q[23:0]) : $signed(dv_q[23:0]);
            state <= S_TT;
          end
        end
        S_TT: state <= S_D2;
        S_D2: begin
          d2    <= d2_new;
          state <= S_CMP;
        end
        S_CMP: begin
          if (d2_gt) begin
            k     <= k + 1'b1;
            state <= S_RD;
          end else begin
            state <= S_THC;
          end
        end
        S_THC: begin
          if (sq_done) begin
            thc   <= sq_root;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if ((t_sat != '0) && ((bestd == '0) || (t_sat < bestd))) begin
            bestd <= t_sat;
            best  <= k[IW-1:0];
          end
          k     <= k + 1'b1;
          state <= S_RD;
        end
        S_FIN: begin
          c     <= CH_RED;
          sr    <= '0;
          sg    <= '0;
          sb    <= '0;
          state <= (bestd == '0) ? S_OUT : S_SH;
        end
        S_SH: begin
          if (bestd >= fq) begin
            if (c == CH_BLUE) state <= S_OUT;
            c <= c + 2'd1;
          end else begin
            state <= S_SHM;
          end
        end
        S_SHM: state <= S_SHW;
        S_SHW: begin
          if (dv_done) begin
            case (c)
              CH_RED:  sr <= dv_q[7:0];
              CH_BLUE: sb <= dv_q[7:0];
              default: sg <= dv_q[7:0];
            endcase
            c     <= c + 2'd1;
            state <= (c == CH_BLUE) ? S_OUT : S_SH;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            hit          <= (bestd != '0);
            nearest_slot <= 3'(best);
            hit_distance <= bestd;
            shade_red    <= sr;
            shade_green  <= sg;
            shade_blue   <= sb;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_hit_has_distance: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit == (hit_distance != 20'd0)))
    else $error("hit flag disagrees with distance");

  a_miss_is_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (nearest_slot == 3'd0 && shade_red == 8'd0 &&
                             shade_green == 8'd0 && shade_blue == 8'd0))
    else $error("miss result carries colour or slot");

  a_units_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    (sq_start |-> !sq_busy) and (dv_start |-> !dv_busy))
    else $error("arithmetic unit restarted while busy");

endmodule
`default_nettype wire

/* sv/ray_sphere_nearest_hit_shader.sv */
// Top level of the ray-sphere nearest-hit shader: configuration registers,
// front end queue and back end. Depends on rss_pkg, rss_front, rss_back.
//
//   Channel  Handshake              Carries
//   in       in_valid / in_ready    op, slot, sphere entry, pixel
//   out      out_valid / out_ready  hit, nearest_slot, hit_distance, shades
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A cast finds the ray length, then takes each active sphere in front of the
// camera through the distance test (one behind it is skipped, and a miss ends
// its test early), then shades and outputs the result, using the 43-step
// divider and 23-step root unit. Reset restores the registers; the table
// holds nothing until written. The two-deep queue keeps input taking items
// while the back end works, and a held result stalls only the back end.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_nearest_hit_shader #(
  parameter int MAX_SPHERES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [2:0]         slot,
  input  wire logic signed [19:0] center_x,
  input  wire logic signed [19:0] center_y,
  input  wire logic signed [19:0] center_z,
  input  wire logic [15:0]        radius,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  input  wire logic [6:0]         pixel_x,
  input  wire logic [6:0]         pixel_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic [2:0]              nearest_slot,
  output logic [19:0]             hit_distance,
  output logic [7:0]              shade_red,
  output logic [7:0]              shade_green,
  output logic [7:0]              shade_blue,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);

  rss_pkg::cfg_t cfg;
  rss_pkg::cmd_t in_cmd;
  rss_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_pop;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x      <= rss_pkg::CAMERA_X_RST;
      cfg.camera_y      <= rss_pkg::CAMERA_Y_RST;
      cfg.camera_z      <= rss_pkg::CAMERA_Z_RST;
      cfg.fade_distance <= rss_pkg::FADE_RST;
      cfg.sphere_count  <= rss_pkg::COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rss_pkg::CFG_CAMERA_X:      cfg.camera_x      <= cfg_data;
        rss_pkg::CFG_CAMERA_Y:      cfg.camera_y      <= cfg_data;
        rss_pkg::CFG_CAMERA_Z:      cfg.camera_z      <= cfg_data;
        rss_pkg::CFG_FADE_DISTANCE: cfg.fade_distance <= cfg_data[11:0];
        rss_pkg::CFG_SPHERE_COUNT:  cfg.sphere_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Gather the input fields
  always_comb begin
    in_cmd.op       = op;
    in_cmd.slot     = slot;
    in_cmd.center_x = center_x;
    in_cmd.center_y = center_y;
    in_cmd.center_z = center_z;
    in_cmd.radius   = radius;
    in_cmd.red      = red;
    in_cmd.green    = green;
    in_cmd.blue     = blue;
    in_cmd.pixel_x  = pixel_x;
    in_cmd.pixel_y  = pixel_y;
  end

  rss_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  rss_back #(.MAX_SPHERES(MAX_SPHERES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .nearest_slot(nearest_slot), .hit_distance(hit_distance),
    .shade_red(shade_red), .shade_green(shade_green), .shade_blue(shade_blue)
  );

endmodule
`default_nettype wire
